### rtl/core/gapf_pkg.sv
// Shared types and constants for the grid A* path finder.
`timescale 1ns / 1ps
`default_nettype none
package gapf_pkg;
	localparam int GRID_W_DEF = 8;
	localparam int GRID_H_DEF = 8;
	localparam logic [9:0] STEP_COST = 10'd10;
	localparam int CFG_REG_W = 4;

	// Direction codes: the step by which a cell was reached.
	localparam logic [1:0] DIR_UP    = 2'd0;
	localparam logic [1:0] DIR_RIGHT = 2'd1;
	localparam logic [1:0] DIR_DOWN  = 2'd2;
	localparam logic [1:0] DIR_LEFT  = 2'd3;

	// Register indexes on the configuration port.
	localparam logic REG_WIDTH  = 1'b0;
	localparam logic REG_HEIGHT = 1'b1;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic map_write;    // write walkable bit from request
		logic load;         // capture find request, clear flags
		logic scan_clear;   // reset the minimum search
		logic scan_step;    // examine one cell for the minimum
		logic expand_init;  // close best cell, start neighbor pass
		logic expand_step;  // relax one neighbor
		logic trace_init;   // start back-tracing from the goal
		logic trace_step;   // step one cell toward the start
		logic emit_load;    // load emit pointer from trace length
		logic emit_step;    // drive one path cell, move toward goal
		logic emit_none;    // drive the no-path result
	} gapf_cmd_t;

	// Status from the datapath to the controller.
	typedef struct packed {
		logic endpoints_ok;
		logic scan_done;
		logic best_valid;
		logic best_is_goal;
		logic expand_done;
		logic trace_done;
		logic emit_done;
	} gapf_sts_t;
endpackage
`default_nettype wire

### rtl/core/gapf_ctrl.sv
// Controller state machine for the grid A* path finder.
`timescale 1ns / 1ps
`default_nettype none
module gapf_ctrl (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                start,
	input  wire logic                operation,
	input  wire gapf_pkg::gapf_sts_t sts,
	output gapf_pkg::gapf_cmd_t      cmd,
	output logic                     busy
);
	typedef enum logic [3:0] {
		ST_IDLE, ST_CHECK, ST_SCAN, ST_PICK, ST_EXPAND, ST_TRACE,
		ST_EMIT_LOAD, ST_EMIT, ST_NONE
	} state_t;

	state_t state_q;

	always_comb begin
		cmd = '0;
		unique case (state_q)
			ST_IDLE: begin
				cmd.map_write = start && !operation;
				cmd.load = start && operation;
			end
			ST_CHECK:     cmd.scan_clear = sts.endpoints_ok;
			ST_SCAN:      cmd.scan_step = 1'b1;
			ST_PICK: begin
				cmd.expand_init = sts.best_valid && !sts.best_is_goal;
				cmd.trace_init = sts.best_valid && sts.best_is_goal;
			end
			ST_EXPAND: begin
				cmd.expand_step = 1'b1;
				cmd.scan_clear = sts.expand_done;
			end
			ST_TRACE:     cmd.trace_step = !sts.trace_done;
			ST_EMIT_LOAD: cmd.emit_load = 1'b1;
			ST_EMIT:      cmd.emit_step = 1'b1;
			ST_NONE:      cmd.emit_none = 1'b1;
			default:      cmd = '0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			unique case (state_q)
				ST_IDLE: if (start && operation) state_q <= ST_CHECK;
				ST_CHECK: state_q <= sts.endpoints_ok ? ST_SCAN : ST_NONE;
				ST_SCAN: if (sts.scan_done) state_q <= ST_PICK;
				ST_PICK: begin
					if (!sts.best_valid) state_q <= ST_NONE;
					else if (sts.best_is_goal) state_q <= ST_TRACE;
					else state_q <= ST_EXPAND;
				end
				ST_EXPAND: if (sts.expand_done) state_q <= ST_SCAN;
				ST_TRACE: if (sts.trace_done) state_q <= ST_EMIT_LOAD;
				ST_EMIT_LOAD: state_q <= ST_EMIT;
				ST_EMIT: if (sts.emit_done) state_q <= ST_IDLE;
				ST_NONE: state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
endmodule
`default_nettype wire

### rtl/core/gapf_dp.sv
// Datapath for the grid A* path finder: cell stores, minimum scan, relax, trace.
`timescale 1ns / 1ps
`default_nettype none
module gapf_dp #(
	parameter int GRID_W = gapf_pkg::GRID_W_DEF,
	parameter int GRID_H = gapf_pkg::GRID_H_DEF
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire gapf_pkg::gapf_cmd_t cmd,
	output gapf_pkg::gapf_sts_t      sts,
	input  wire logic [3:0]          width_cfg,
	input  wire logic [3:0]          height_cfg,
	input  wire logic [2:0]          cell_x,
	input  wire logic [2:0]          cell_y,
	input  wire logic                walkable_value,
	input  wire logic [2:0]          start_x,
	input  wire logic [2:0]          start_y,
	input  wire logic [2:0]          end_x,
	input  wire logic [2:0]          end_y,
	output logic                     found,
	output logic [2:0]               path_x,
	output logic [2:0]               path_y,
	output logic                     last,
	output logic                     result_valid
);
	localparam int CELLS = GRID_W * GRID_H;
	localparam int IW = (CELLS > 1) ? $clog2(CELLS) : 1;
	localparam int CW = $clog2(CELLS + 1);

	// Walkable bits, reset to all walkable; open/closed flags per cell.
	logic [CELLS-1:0] walk_q, open_q, closed_q;
	// Undefined-until-written stores as memories.
	logic [9:0] cost_mem [CELLS];
	logic [1:0] dir_mem  [CELLS];
	logic [7:0] ord_mem  [CELLS];

	logic [2:0] sx_q, sy_q, ex_q, ey_q;
	logic [3:0] uw, uh;
	assign uw = (width_cfg > 4'(GRID_W)) ? 4'(GRID_W) : width_cfg;
	assign uh = (height_cfg > 4'(GRID_H)) ? 4'(GRID_H) : height_cfg;

	function automatic logic [IW-1:0] idx_of(input logic [2:0] x, input logic [2:0] y);
		return IW'(32'(y) * GRID_W + 32'(x));
	endfunction

	// Minimum scan: one cell per cycle, memory read registered.
	logic [CW-1:0] scan_q;
	logic          rd_v_s1;
	logic [IW-1:0] rd_i_s1;
	logic [2:0]    rd_x_s1, rd_y_s1;
	logic [9:0]    rd_cost;
	logic [7:0]    rd_ord;
	logic          best_v_q;
	logic [IW-1:0] best_i_q;
	logic [2:0]    best_x_q, best_y_q;
	logic [10:0]   best_f_q;
	logic [3:0]    best_h_q;
	logic [7:0]    best_o_q;
	logic [9:0]    best_g_q;
	logic [7:0]    order_q;

	// Column and row of the scanned cell, stepped alongside scan_q.
	logic [2:0] scx_q, scy_q;

	function automatic logic [3:0] mdist(input logic [2:0] x, input logic [2:0] y,
			input logic [2:0] x2, input logic [2:0] y2);
		logic [2:0] a, b;
		a = (x > x2) ? x - x2 : x2 - x;
		b = (y > y2) ? y - y2 : y2 - y;
		return {1'b0, a} + {1'b0, b};
	endfunction

	logic [3:0]  cand_h;
	logic [10:0] cand_f;
	logic        cand_better;
	assign cand_h = mdist(rd_x_s1, rd_y_s1, ex_q, ey_q);
	assign cand_f = {1'b0, rd_cost} + 11'(cand_h);
	assign cand_better = !best_v_q || cand_f < best_f_q ||
		(cand_f == best_f_q && cand_h < best_h_q) ||
		(cand_f == best_f_q && cand_h == best_h_q && rd_ord < best_o_q);

	// Neighbor relax: read phase then write phase per direction.
	logic [2:0] ex_d_q;   // direction counter 0..4
	logic       ex_ph_q;  // 0 = read, 1 = write
	logic [2:0] nb_x, nb_y;
	logic       nb_in;
	logic [1:0] dsel;
	assign dsel = ex_d_q[1:0];
	always_comb begin
		nb_x = best_x_q;
		nb_y = best_y_q;
		nb_in = 1'b0;
		unique case (dsel)
			gapf_pkg::DIR_UP: begin
				nb_y = best_y_q - 3'd1; nb_in = best_y_q != 3'd0;
			end
			gapf_pkg::DIR_RIGHT: begin
				nb_x = best_x_q + 3'd1; nb_in = 4'(best_x_q) + 4'd1 < uw;
			end
			gapf_pkg::DIR_DOWN: begin
				nb_y = best_y_q + 3'd1; nb_in = 4'(best_y_q) + 4'd1 < uh;
			end
			gapf_pkg::DIR_LEFT: begin
				nb_x = best_x_q - 3'd1; nb_in = best_x_q != 3'd0;
			end
			default: nb_in = 1'b0;
		endcase
	end
	logic [IW-1:0] nb_i;
	logic [9:0]    g_new;
	assign nb_i = idx_of(nb_x, nb_y);
	assign g_new = best_g_q + gapf_pkg::STEP_COST;
	logic nb_ok;
	assign nb_ok = nb_in && walk_q[nb_i] && !closed_q[nb_i];

	// Trace back and emit.
	logic [2:0]    tx_q, ty_q;
	logic [IW-1:0] ti_q;
	logic [2:0]    px_mem [CELLS];
	logic [2:0]    py_mem [CELLS];
	logic [CW-1:0] tn_q, ek_q;
	logic [1:0]    rd_dir;
	logic          tr_ph_q;
	logic          tr_done_q;

	logic ep_ok;
	assign ep_ok = (4'(sx_q) < uw) && (4'(sy_q) < uh) && (4'(ex_q) < uw) &&
		(4'(ey_q) < uh) && walk_q[idx_of(sx_q, sy_q)] && walk_q[idx_of(ex_q, ey_q)];

	// Shared memory read address.
	logic [IW-1:0] mem_ra;
	always_comb begin
		if (cmd.expand_step) mem_ra = nb_i;
		else if (cmd.trace_step) mem_ra = ti_q;
		else mem_ra = scan_q[IW-1:0];
	end
	always_ff @(posedge clk) begin
		rd_cost <= cost_mem[mem_ra];
		rd_dir  <= dir_mem[mem_ra];
		rd_ord  <= ord_mem[mem_ra];
	end

	// Memory writes.
	logic          mw_en;
	logic [IW-1:0] mw_i;
	logic [9:0]    mw_cost;
	logic [1:0]    mw_dir;
	logic [7:0]    mw_ord;
	logic          mw_ord_en;
	always_comb begin
		mw_en = 1'b0; mw_ord_en = 1'b0;
		mw_i = nb_i; mw_cost = g_new; mw_dir = dsel; mw_ord = order_q;
		if (cmd.load) begin
			mw_en = 1'b1; mw_ord_en = 1'b1;
			mw_i = idx_of(start_x, start_y); mw_cost = '0; mw_dir = gapf_pkg::DIR_UP;
			mw_ord = '0;
		end else if (cmd.expand_step && ex_ph_q && ex_d_q[2] == 1'b0 && nb_ok) begin
			if (!open_q[nb_i]) begin
				mw_en = 1'b1; mw_ord_en = 1'b1;
			end else if (g_new < rd_cost) begin
				mw_en = 1'b1;
			end
		end
	end
	always_ff @(posedge clk) begin
		if (mw_en) begin
			cost_mem[mw_i] <= mw_cost;
			dir_mem[mw_i] <= mw_dir;
		end
		if (mw_ord_en) ord_mem[mw_i] <= mw_ord;
	end
	always_ff @(posedge clk) begin
		if (cmd.trace_step && !tr_ph_q) begin
			px_mem[tn_q[IW-1:0]] <= tx_q;
			py_mem[tn_q[IW-1:0]] <= ty_q;
		end
	end
	// Read one cell ahead so the registered path cell is ready on each emit cycle.
	logic [CW-1:0] em_ra;
	assign em_ra = (cmd.emit_load ? tn_q : ek_q) - CW'(1);
	logic [2:0] em_x, em_y;
	always_ff @(posedge clk) begin
		em_x <= px_mem[em_ra[IW-1:0]];
		em_y <= py_mem[em_ra[IW-1:0]];
	end

	logic [2:0] bx_back, by_back;
	always_comb begin
		bx_back = tx_q; by_back = ty_q;
		unique case (rd_dir)
			gapf_pkg::DIR_UP:    by_back = ty_q + 3'd1;
			gapf_pkg::DIR_RIGHT: bx_back = tx_q - 3'd1;
			gapf_pkg::DIR_DOWN:  by_back = ty_q - 3'd1;
			gapf_pkg::DIR_LEFT:  bx_back = tx_q + 3'd1;
			default:             bx_back = tx_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			walk_q <= '1; open_q <= '0; closed_q <= '0;
			scan_q <= '0; rd_v_s1 <= 1'b0; best_v_q <= 1'b0;
			scx_q <= '0; scy_q <= '0;
			ex_d_q <= '0; ex_ph_q <= 1'b0; order_q <= '0;
			tn_q <= '0; ek_q <= '0; tr_ph_q <= 1'b0; tr_done_q <= 1'b0;
			result_valid <= 1'b0; found <= 1'b0; last <= 1'b0;
			path_x <= '0; path_y <= '0;
		end else begin
			result_valid <= 1'b0;
			rd_v_s1 <= 1'b0;
			if (cmd.map_write && 32'(cell_x) < GRID_W && 32'(cell_y) < GRID_H)
				walk_q[idx_of(cell_x, cell_y)] <= walkable_value;
			if (cmd.load) begin
				sx_q <= start_x; sy_q <= start_y; ex_q <= end_x; ey_q <= end_y;
				open_q <= '0; closed_q <= '0;
				if (32'(start_x) < GRID_W && 32'(start_y) < GRID_H)
					open_q[idx_of(start_x, start_y)] <= 1'b1;
				order_q <= 8'd1;
			end
			if (cmd.scan_clear) begin
				scan_q <= '0; best_v_q <= 1'b0;
				scx_q <= '0; scy_q <= '0;
			end
			if (cmd.scan_step) begin
				if (scan_q < CW'(CELLS)) begin
					rd_v_s1 <= open_q[scan_q[IW-1:0]];
					rd_i_s1 <= scan_q[IW-1:0];
					rd_x_s1 <= scx_q; rd_y_s1 <= scy_q;
					scan_q <= scan_q + CW'(1);
					if (32'(scx_q) == GRID_W - 1) begin
						scx_q <= '0; scy_q <= scy_q + 3'd1;
					end else begin
						scx_q <= scx_q + 3'd1;
					end
				end
				if (rd_v_s1 && cand_better) begin
					best_v_q <= 1'b1; best_i_q <= rd_i_s1;
					best_x_q <= rd_x_s1; best_y_q <= rd_y_s1;
					best_f_q <= cand_f; best_h_q <= cand_h; best_o_q <= rd_ord;
					best_g_q <= rd_cost;
				end
			end
			if (cmd.expand_init) begin
				open_q[best_i_q] <= 1'b0; closed_q[best_i_q] <= 1'b1;
				ex_d_q <= '0; ex_ph_q <= 1'b0;
			end
			if (cmd.expand_step && ex_d_q[2] == 1'b0) begin
				ex_ph_q <= !ex_ph_q;
				if (ex_ph_q) begin
					ex_d_q <= ex_d_q + 3'd1;
					if (nb_ok && !open_q[nb_i]) begin
						open_q[nb_i] <= 1'b1;
						order_q <= order_q + 8'd1;
					end
				end
			end
			if (cmd.trace_init) begin
				tx_q <= best_x_q; ty_q <= best_y_q; ti_q <= best_i_q;
				tn_q <= '0; tr_ph_q <= 1'b0;
				tr_done_q <= 1'b0;
			end
			if (cmd.trace_step) begin
				tr_ph_q <= !tr_ph_q;
				if (!tr_ph_q) begin
					tn_q <= tn_q + CW'(1);
					if ((tx_q == sx_q && ty_q == sy_q) || tn_q + CW'(1) >= CW'(CELLS)) begin
						tr_done_q <= 1'b1; tr_ph_q <= 1'b0;
					end
				end else begin
					tx_q <= bx_back; ty_q <= by_back;
					ti_q <= idx_of(bx_back, by_back);
				end
			end
			if (cmd.emit_load) ek_q <= tn_q - CW'(1);
			if (cmd.emit_step) begin
				result_valid <= 1'b1; found <= 1'b1;
				path_x <= em_x; path_y <= em_y;
				last <= (ek_q == '0);
				ek_q <= ek_q - CW'(1);
			end
			if (cmd.emit_none) begin
				result_valid <= 1'b1; found <= 1'b0; last <= 1'b1;
				path_x <= '0; path_y <= '0;
			end
		end
	end

	always_comb begin
		sts.endpoints_ok = ep_ok;
		sts.scan_done = (scan_q == CW'(CELLS)) && !rd_v_s1;
		sts.best_valid = best_v_q;
		sts.best_is_goal = (best_x_q == ex_q) && (best_y_q == ey_q);
		sts.expand_done = ex_d_q[2];
		sts.trace_done = tr_done_q;
		sts.emit_done = (ek_q == '0);
	end
endmodule
`default_nettype wire

### rtl/core/grid_astar_path_finder.sv
// Top level of the grid A* path finder: config registers, controller, datapath.
`timescale 1ns / 1ps
`default_nettype none
// A request with operation 0 writes one walkable bit at the accepting edge, keeps
// busy low and gives no result. A find request scans all GRID_W*GRID_H cells for
// the least-cost open cell (one cell per cycle, through the registered cost memory
// port) and then relaxes the four neighbors, each in a read and a write phase;
// this repeats until the goal cell is picked or no open cell is left. The path
// is then traced back from the goal to the start and emitted one cell per cycle.
// Results appear with strobe high for one cycle each and cannot be held off;
// busy stays high until the last one is out.
module grid_astar_path_finder #(
	parameter int GRID_W = gapf_pkg::GRID_W_DEF,
	parameter int GRID_H = gapf_pkg::GRID_H_DEF
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        psel,
	input  wire logic        penable,
	input  wire logic        pwrite,
	input  wire logic [2:0]  paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0]      prdata,
	output logic             pready,
	input  wire logic        start,
	output logic             busy,
	input  wire logic        operation,
	input  wire logic [2:0]  cell_x,
	input  wire logic [2:0]  cell_y,
	input  wire logic        walkable_value,
	input  wire logic [2:0]  start_x,
	input  wire logic [2:0]  start_y,
	input  wire logic [2:0]  end_x,
	input  wire logic [2:0]  end_y,
	output logic             strobe,
	output logic             found,
	output logic [2:0]       path_x,
	output logic [2:0]       path_y,
	output logic             last
);
	logic [3:0] width_q, height_q;
	logic       wr_en;
	logic       reg_sel;
	assign pready = 1'b1;
	assign reg_sel = paddr[2];
	assign wr_en = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q <= 4'd8; height_q <= 4'd8;
		end else if (wr_en && paddr[1:0] == 2'd0) begin
			unique case (reg_sel)
				gapf_pkg::REG_WIDTH:  width_q <= pwdata[3:0];
				gapf_pkg::REG_HEIGHT: height_q <= pwdata[3:0];
				default:              width_q <= width_q;
			endcase
		end
	end
	always_comb begin
		unique case (reg_sel)
			gapf_pkg::REG_WIDTH:  prdata = {28'd0, width_q};
			gapf_pkg::REG_HEIGHT: prdata = {28'd0, height_q};
			default:              prdata = '0;
		endcase
	end

	gapf_pkg::gapf_cmd_t cmd;
	gapf_pkg::gapf_sts_t sts;

	gapf_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n), .start(start), .operation(operation),
		.sts(sts), .cmd(cmd), .busy(busy)
	);

	gapf_dp #(.GRID_W(GRID_W), .GRID_H(GRID_H)) u_dp (
		.clk(clk), .arst_n(arst_n), .cmd(cmd), .sts(sts),
		.width_cfg(width_q), .height_cfg(height_q),
		.cell_x(cell_x), .cell_y(cell_y), .walkable_value(walkable_value),
		.start_x(start_x), .start_y(start_y), .end_x(end_x), .end_y(end_y),
		.found(found), .path_x(path_x), .path_y(path_y), .last(last),
		.result_valid(strobe)
	);

	// A no-path result always carries a zero cell.
	a_nopath_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !found |-> path_x == 3'd0 && path_y == 3'd0 && last)
		else $error("no-path result with nonzero cell");
	// The last result of a search ends the busy period.
	a_last_idle: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && last |-> !busy)
		else $error("busy after last result");
	// A write request never produces a result.
	a_write_silent: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy && !operation |=> !strobe)
		else $error("result after a map write");
endmodule
`default_nettype wire

### tb/tb.sv
// Self-checking testbench for grid_astar_path_finder: directed and random map edits and path searches.
`timescale 1ns / 1ps
module tb;
	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_FIND  = 1'b1;
	localparam int CYCLE_LIMIT = 3000000;

	typedef struct {
		logic       operation;
		logic [2:0] cell_x, cell_y;
		logic       walkable_value;
		logic [2:0] start_x, start_y, end_x, end_y;
	} grid_req_t;

	typedef struct {
		logic       found;
		logic [2:0] path_x, path_y;
		logic       last;
	} path_cell_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [2:0] paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic pready;
	logic start = 1'b0;
	logic busy;
	logic operation = 1'b0;
	logic [2:0] cell_x = '0, cell_y = '0, start_x = '0, start_y = '0, end_x = '0, end_y = '0;
	logic walkable_value = 1'b0;
	logic strobe, found, last;
	logic [2:0] path_x, path_y;

	grid_astar_path_finder u_dut (.*);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	grid_req_t  pending_reqs[$];
	path_cell_t expected_cells[$];
	int errors = 0;
	int idle_pct = 0;
	int cycles = 0;

	function automatic void add_req(grid_req_t r);
		pending_reqs = {pending_reqs, r};
	endfunction

	function automatic void add_cell(path_cell_t c);
		expected_cells = {expected_cells, c};
	endfunction

	// shadow of the block state
	logic [3:0] width_reg = 4'd8, height_reg = 4'd8;
	logic       walk_map[64];
	bit         open_f[64], closed_f[64];
	logic [9:0] g_cost[64];
	logic [1:0] parent_dir[64];
	logic [7:0] ins_order[64];

	function automatic int used_w();
		return (width_reg > 8) ? 8 : int'(width_reg);
	endfunction

	function automatic int used_h();
		return (height_reg > 8) ? 8 : int'(height_reg);
	endfunction

	function automatic bit on_grid(int x, int y);
		return x >= 0 && y >= 0 && x < used_w() && y < used_h();
	endfunction

	function automatic void push_no_path();
		path_cell_t c;
		c.found = 1'b0; c.path_x = '0; c.path_y = '0; c.last = 1'b1;
		add_cell(c);
	endfunction

	function automatic void find_path(int sx, int sy, int ex, int ey);
		int dx[4] = '{0, 1, 0, -1};
		int dy[4] = '{-1, 0, 1, 0};
		int order, si, ei, best, bx, by, bf, bh, h, f, nx, ny, ni, n, x, y, d;
		logic [9:0] g;
		int px[64], py[64];
		path_cell_t c;
		if (!on_grid(sx, sy) || !on_grid(ex, ey)) begin
			push_no_path();
			return;
		end
		si = sy * 8 + sx;
		ei = ey * 8 + ex;
		if (!walk_map[si] || !walk_map[ei]) begin
			push_no_path();
			return;
		end
		for (int i = 0; i < 64; i++) begin
			open_f[i] = 0;
			closed_f[i] = 0;
		end
		order = 0;
		open_f[si] = 1; g_cost[si] = '0; parent_dir[si] = gapf_pkg::DIR_UP;
		ins_order[si] = 8'(order++);
		forever begin
			best = -1; bx = 0; by = 0; bf = 0; bh = 0;
			for (int i = 0; i < 64; i++) begin
				if (!open_f[i]) continue;
				h = ((i % 8 > ex) ? i % 8 - ex : ex - i % 8) + ((i / 8 > ey) ? i / 8 - ey : ey - i / 8);
				f = int'(g_cost[i]) + h;
				if (best < 0 || f < bf || (f == bf && h < bh) ||
				    (f == bf && h == bh && ins_order[i] < ins_order[best])) begin
					best = i; bf = f; bh = h; bx = i % 8; by = i / 8;
				end
			end
			if (best < 0) begin
				push_no_path();
				return;
			end
			if (best == ei) begin
				n = 0; x = bx; y = by;
				while (n < 64) begin
					px[n] = x; py[n] = y; n++;
					if (x == sx && y == sy) break;
					d = parent_dir[y * 8 + x];
					x -= dx[d]; y -= dy[d];
					if (x < 0 || y < 0 || x >= 8 || y >= 8) break;
				end
				for (int k = 0; k < n; k++) begin
					c.found = 1'b1;
					c.path_x = 3'(px[n - 1 - k]);
					c.path_y = 3'(py[n - 1 - k]);
					c.last = (k == n - 1);
					add_cell(c);
				end
				return;
			end
			open_f[best] = 0;
			closed_f[best] = 1;
			for (d = 0; d < 4; d++) begin
				nx = bx + dx[d]; ny = by + dy[d];
				if (!on_grid(nx, ny)) continue;
				ni = ny * 8 + nx;
				if (!walk_map[ni] || closed_f[ni]) continue;
				g = g_cost[best] + gapf_pkg::STEP_COST;
				if (!open_f[ni]) begin
					open_f[ni] = 1; g_cost[ni] = g; parent_dir[ni] = 2'(d);
					ins_order[ni] = 8'(order++);
				end else if (g < g_cost[ni]) begin
					g_cost[ni] = g; parent_dir[ni] = 2'(d);
				end
			end
		end
	endfunction

	function automatic void predict(grid_req_t r);
		if (r.operation == OP_WRITE)
			walk_map[r.cell_y * 8 + r.cell_x] = r.walkable_value;
		else
			find_path(r.start_x, r.start_y, r.end_x, r.end_y);
	endfunction

	// request driver
	always @(posedge clk or negedge arst_n) begin
		grid_req_t r;
		if (!arst_n) begin
			start <= 1'b0;
		end else begin
			if (start && !busy)
				predict('{operation, cell_x, cell_y, walkable_value, start_x, start_y, end_x, end_y});
			if (!start || !busy) begin
				if (pending_reqs.size() > 0 && $urandom_range(99) >= idle_pct) begin
					r = pending_reqs.pop_front();
					operation <= r.operation; cell_x <= r.cell_x; cell_y <= r.cell_y;
					walkable_value <= r.walkable_value;
					start_x <= r.start_x; start_y <= r.start_y;
					end_x <= r.end_x; end_y <= r.end_y;
					start <= 1'b1;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// result monitor
	always @(posedge clk) begin
		path_cell_t e;
		if (arst_n && strobe) begin
			if (expected_cells.size() == 0) begin
				$display("%0t: unexpected result found=%0d x=%0d y=%0d last=%0d",
				         $time, found, path_x, path_y, last);
				errors++;
			end else begin
				e = expected_cells.pop_front();
				if (found !== e.found) begin
					$display("%0t: found exp %0d act %0d", $time, e.found, found); errors++;
				end
				if (path_x !== e.path_x) begin
					$display("%0t: path_x exp %0d act %0d", $time, e.path_x, path_x); errors++;
				end
				if (path_y !== e.path_y) begin
					$display("%0t: path_y exp %0d act %0d", $time, e.path_y, path_y); errors++;
				end
				if (last !== e.last) begin
					$display("%0t: last exp %0d act %0d", $time, e.last, last); errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	function automatic grid_req_t mk(logic op, int cx, int cy, logic wv, int sx, int sy,
	                                 int ex, int ey);
		grid_req_t r;
		r.operation = op; r.cell_x = 3'(cx); r.cell_y = 3'(cy); r.walkable_value = wv;
		r.start_x = 3'(sx); r.start_y = 3'(sy); r.end_x = 3'(ex); r.end_y = 3'(ey);
		return r;
	endfunction

	function automatic int pick_coord(int lim);
		if (lim > 0 && $urandom_range(9) < 8)
			return $urandom_range(lim - 1);
		return $urandom_range(7);
	endfunction

	function automatic grid_req_t rand_req();
		grid_req_t r;
		r = mk($urandom_range(99) >= 45, $urandom_range(7), $urandom_range(7),
		       $urandom_range(99) < 55, $urandom_range(7), $urandom_range(7),
		       $urandom_range(7), $urandom_range(7));
		if (r.operation == OP_WRITE) begin
			r.cell_x = 3'(pick_coord(used_w()));
			r.cell_y = 3'(pick_coord(used_h()));
		end else begin
			r.start_x = 3'(pick_coord(used_w())); r.start_y = 3'(pick_coord(used_h()));
			r.end_x = 3'(pick_coord(used_w()));   r.end_y = 3'(pick_coord(used_h()));
		end
		return r;
	endfunction

	task automatic wait_idle();
		while (pending_reqs.size() > 0 || start || expected_cells.size() > 0 || busy)
			@(posedge clk);
		repeat (20) @(posedge clk);
	endtask

	task automatic reg_write(logic idx, logic [3:0] value);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= 32'(value);
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		while (!pready) @(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		if (idx == gapf_pkg::REG_WIDTH) width_reg = value;
		else height_reg = value;
	endtask

	initial begin
		int widths[7]  = '{8, 1, 8, 0, 15, 4, 5};
		int heights[7] = '{8, 8, 1, 5, 3, 4, 7};
		int idles[7]   = '{0, 75, 15, 0, 75, 15, 0};
		for (int i = 0; i < 64; i++) walk_map[i] = 1'b1;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: corners, start equal to end, blocked endpoints, walled-off goal
		add_req(mk(OP_FIND, 7, 7, 1, 0, 0, 7, 7));
		add_req(mk(OP_FIND, 0, 0, 0, 7, 7, 0, 0));
		add_req(mk(OP_FIND, 5, 2, 1, 3, 4, 3, 4));
		add_req(mk(OP_WRITE, 0, 0, 0, 7, 7, 7, 7));
		add_req(mk(OP_FIND, 0, 0, 0, 0, 0, 5, 5));
		add_req(mk(OP_FIND, 0, 0, 0, 5, 5, 0, 0));
		add_req(mk(OP_WRITE, 0, 0, 1, 0, 0, 0, 0));
		add_req(mk(OP_WRITE, 6, 7, 0, 0, 0, 0, 0));
		add_req(mk(OP_WRITE, 7, 6, 0, 0, 0, 0, 0));
		add_req(mk(OP_FIND, 0, 0, 0, 0, 0, 7, 7));
		add_req(mk(OP_FIND, 7, 7, 1, 7, 7, 2, 3));
		add_req(mk(OP_WRITE, 7, 6, 1, 0, 0, 0, 0));
		add_req(mk(OP_FIND, 3, 3, 0, 0, 7, 7, 0));
		// vertical wall with one gap
		for (int y = 0; y < 7; y++)
			add_req(mk(OP_WRITE, 3, y, 0, 0, 0, 0, 0));
		add_req(mk(OP_FIND, 0, 0, 0, 0, 0, 6, 0));
		add_req(mk(OP_FIND, 0, 0, 0, 6, 1, 1, 1));

		for (int p = 0; p < 7; p++) begin
			wait_idle();
			reg_write(gapf_pkg::REG_WIDTH, 4'(widths[p]));
			reg_write(gapf_pkg::REG_HEIGHT, 4'(heights[p]));
			idle_pct = idles[p];
			for (int k = 0; k < 16; k++) add_req(rand_req());
		end
		wait_idle();
		if (errors == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end
endmodule
